### hw/rtl/pcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_pkg: shared types, constants and stage functions
// Pipeline item record, result record, register codes and per-stage math.
// ----------------------------------------------------------------------------
package pcg_pkg;

	localparam int unsigned NSTG      = 53;
	localparam int unsigned CORDIC_N  = 20;
	localparam logic signed [26:0] ANG_HALF = 27'sd18432000;
	localparam logic signed [26:0] ANG_RND  = 27'sd512;
	localparam logic signed [16:0] A180     = 17'sd18000;
	localparam logic signed [16:0] A90      = 17'sd9000;
	localparam logic signed [15:0] Q_MAX    = 16'sd32767;
	localparam logic signed [15:0] Q_MIN    = -16'sd32768;
	localparam logic signed [16:0] CY_RESET = 17'sd5400;

	localparam logic [22:0] ATAN_TAB [CORDIC_N] = '{
		23'd4608000, 23'd2720261, 23'd1437311, 23'd729602, 23'd366217,
		23'd183287, 23'd91666, 23'd45836, 23'd22918, 23'd11459,
		23'd5730, 23'd2865, 23'd1432, 23'd716, 23'd358,
		23'd179, 23'd90, 23'd45, 23'd22, 23'd11
	};

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1
	} cfg_reg_e;

	typedef struct packed {
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic [33:0]        sq_x;
		logic [33:0]        sq_y;
		logic [34:0]        s;
		logic [19:0]        d_rem;
		logic [17:0]        d_root;
		logic [34:0]        qx_rem;
		logic [34:0]        qy_rem;
		logic [32:0]        qx;
		logic [32:0]        qy;
		logic [18:0]        kx_rem;
		logic [18:0]        ky_rem;
		logic [16:0]        kx_root;
		logic [16:0]        ky_root;
		logic signed [32:0] cx;
		logic signed [32:0] cy;
		logic signed [26:0] cz;
		logic signed [26:0] cbase;
	} item_t;

	typedef struct packed {
		logic [17:0]        distance_mm;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] heading_cdeg;
	} res_t;

	function automatic logic [16:0] mag17(input logic signed [17:0] v);
		logic signed [17:0] n;
		n = -v;
		return v[17] ? n[16:0] : v[16:0];
	endfunction

	// one restoring step of a two-bits-per-step integer square root
	function automatic logic [127:0] sqrt_step(input logic [63:0] rem,
			input logic [63:0] root, input logic [1:0] pair);
		logic [63:0] rem2;
		logic [63:0] trial;
		rem2  = (rem << 2) | 64'(pair);
		trial = (root << 2) | 64'd1;
		if (rem2 >= trial)
			return {rem2 - trial, (root << 1) | 64'd1};
		return {rem2, root << 1};
	endfunction

	// one restoring division step, quotient bit in the low bit of the result
	function automatic logic [35:0] div_step(input logic [34:0] rem,
			input logic bitv, input logic [34:0] s);
		logic [36:0] dr;
		dr = {1'b0, rem, bitv};
		if (dr >= 37'(s))
			return {35'(dr - 37'(s)), 1'b1};
		return {dr[34:0], 1'b0};
	endfunction

	function automatic item_t stage_step(input int unsigned p, input item_t a);
		item_t               r;
		logic [127:0]        sq;
		logic [35:0]         dv;
		logic                bitv;
		logic [33:0]         kin;
		logic signed [32:0]  xs;
		logic signed [32:0]  ys;
		logic signed [26:0]  tab;
		int unsigned         i;
		r = a;
		if (p == 1) begin
			r.sq_x = {17'b0, mag17(a.dx)} * {17'b0, mag17(a.dx)};
			r.sq_y = {17'b0, mag17(a.dy)} * {17'b0, mag17(a.dy)};
		end
		if (p == 2) begin
			r.s       = 35'(a.sq_x) + 35'(a.sq_y);
			r.d_rem   = '0;
			r.d_root  = '0;
			r.qx_rem  = 35'(a.sq_x >> 1);
			r.qy_rem  = 35'(a.sq_y >> 1);
			r.qx      = '0;
			r.qy      = '0;
			r.kx_rem  = '0;
			r.ky_rem  = '0;
			r.kx_root = '0;
			r.ky_root = '0;
			r.cz      = '0;
			if (a.dx[17]) begin
				r.cx    = -(33'(a.dx) <<< 12);
				r.cy    = -(33'(a.dy) <<< 12);
				r.cbase = (a.dy > 0) ? ANG_HALF : -ANG_HALF;
			end else begin
				r.cx    = 33'(a.dx) <<< 12;
				r.cy    = 33'(a.dy) <<< 12;
				r.cbase = '0;
			end
		end
		if (p >= 3 && p <= 35) begin
			i    = 35 - p;
			bitv = (i == 32) ? a.sq_x[0] : 1'b0;
			dv   = div_step(a.qx_rem, bitv, a.s);
			r.qx_rem = dv[35:1];
			r.qx[i]  = dv[0];
			bitv = (i == 32) ? a.sq_y[0] : 1'b0;
			dv   = div_step(a.qy_rem, bitv, a.s);
			r.qy_rem = dv[35:1];
			r.qy[i]  = dv[0];
		end
		if (p >= 3 && p <= 20) begin
			i  = 20 - p;
			sq = sqrt_step(64'(a.d_rem), 64'(a.d_root), 2'({1'b0, a.s} >> (2 * i)));
			r.d_rem  = sq[83:64];
			r.d_root = sq[17:0];
		end
		if (p >= 3 && p <= 22) begin
			i   = p - 3;
			xs  = a.cx >>> i;
			ys  = a.cy >>> i;
			tab = $signed({4'b0, ATAN_TAB[i]});
			if (a.cy > 0) begin
				r.cx = a.cx + ys;
				r.cy = a.cy - xs;
				r.cz = a.cz + tab;
			end else begin
				r.cx = a.cx - ys;
				r.cy = a.cy + xs;
				r.cz = a.cz - tab;
			end
		end
		if (p >= 36 && p <= 52) begin
			i   = 52 - p;
			kin = {1'b0, a.qx};
			sq  = sqrt_step(64'(a.kx_rem), 64'(a.kx_root), 2'(kin >> (2 * i)));
			r.kx_rem  = sq[82:64];
			r.kx_root = sq[16:0];
			kin = {1'b0, a.qy};
			sq  = sqrt_step(64'(a.ky_rem), 64'(a.ky_root), 2'(kin >> (2 * i)));
			r.ky_rem  = sq[82:64];
			r.ky_root = sq[16:0];
		end
		return r;
	endfunction

	// k = isqrt(floor(2^32 m^2 / S)); the rounded component is (k+1)/2
	function automatic logic signed [15:0] unit_q(input logic [16:0] k, input logic neg);
		logic [17:0]        mid;
		logic signed [18:0] n;
		mid = (18'(k) + 18'd1) >> 1;
		n   = -$signed({1'b0, mid});
		if (neg)
			return 16'(n);
		return (mid > 18'd32767) ? Q_MAX : 16'(mid);
	endfunction

	function automatic res_t finish(input item_t a);
		res_t               o;
		logic [18:0]        dist_rnd;
		logic signed [26:0] sum;
		logic signed [16:0] ang;
		sum  = a.cbase + a.cz + ANG_RND;
		ang  = 17'(sum >>> 10);
		if (ang <= -A180 || ang > A180)
			ang = A180;
		if (a.dy == 0)
			ang = a.dx[17] ? A180 : '0;
		else if (a.dx == 0)
			ang = a.dy[17] ? -A90 : A90;
		dist_rnd = 19'(a.d_root);
		if (20'(a.d_rem) > 20'(a.d_root))
			dist_rnd = dist_rnd + 19'd1;
		o.distance_mm = dist_rnd[17:0];
		if (a.s == '0) begin
			o.normal_x     = '0;
			o.normal_y     = '0;
			o.heading_cdeg = -16'sd9000;
		end else begin
			o.normal_x     = unit_q(a.kx_root, a.dx[17]);
			o.normal_y     = unit_q(a.ky_root, a.dy[17]);
			o.heading_cdeg = 16'(ang - A90);
		end
		o.tangent_x = o.normal_y;
		o.tangent_y = (o.normal_x == Q_MIN) ? Q_MAX : -o.normal_x;
		return o;
	endfunction

endpackage

### hw/rtl/point_to_center_geometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_center_geometry: distance, unit normal, tangent and heading
// From request acceptance to out_valid: input register, 52 compute stages
// (holding the 33-step divider and 17-step root), then output register.
// Throughput: one request per cycle while in_stall is low; a two-entry
// output buffer keeps input open while one finished result waits. Reset
// clears all valid bits and loads the centre registers with x = 0, y = 5400.
// ----------------------------------------------------------------------------
module point_to_center_geometry
	import pcg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [16:0]  robot_x_mm,
	input  logic signed [16:0]  robot_y_mm,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [17:0]         distance_mm,
	output logic signed [15:0]  normal_x,
	output logic signed [15:0]  normal_y,
	output logic signed [15:0]  tangent_x,
	output logic signed [15:0]  tangent_y,
	output logic signed [15:0]  heading_cdeg
);

	logic signed [16:0] center_x_q;
	logic signed [16:0] center_y_q;
	item_t              item_s  [NSTG];
	logic [NSTG-1:0]    valid_s;
	res_t               out_q;
	res_t               skid_q;
	res_t               res_nxt;
	logic               out_v_q;
	logic               skid_v_q;
	logic               adv;
	logic               take_out;
	logic               incoming;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= CY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s <= '0;
		else if (adv)
			valid_s <= {valid_s[NSTG-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (adv)
			item_s[0] <= '{dx: 18'(center_x_q) - 18'(robot_x_mm),
				dy: 18'(center_y_q) - 18'(robot_y_mm), default: '0};
	end

	for (genvar p = 1; p < NSTG; p++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv)
				item_s[p] <= stage_step(p, item_s[p-1]);
		end
	end

	assign res_nxt  = finish(item_s[NSTG-1]);
	assign take_out = out_v_q && !out_stall;
	assign incoming = adv && valid_s[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take_out)
				skid_v_q <= 1'b0;
		end else if (!out_v_q || take_out) begin
			out_v_q <= incoming;
		end else if (incoming) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take_out)
				out_q <= skid_q;
		end else if (!out_v_q || take_out) begin
			if (incoming)
				out_q <= res_nxt;
		end else if (incoming) begin
			skid_q <= res_nxt;
		end
	end

	assign out_valid    = out_v_q;
	assign distance_mm  = out_q.distance_mm;
	assign normal_x     = out_q.normal_x;
	assign normal_y     = out_q.normal_y;
	assign tangent_x    = out_q.tangent_x;
	assign tangent_y    = out_q.tangent_y;
	assign heading_cdeg = out_q.heading_cdeg;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output entry");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && out_stall))
		else $error("skid filled while output was free");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && distance_mm == '0) |->
			(heading_cdeg == -16'sd9000 && normal_x == '0 && normal_y == '0))
		else $error("zero difference gave a nonzero direction");

	a_tangent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tangent_x == normal_y))
		else $error("tangent x differs from normal y");

endmodule
